### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLKRST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: label");

// Check a property on every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: label");

`endif

### hdl/tcic_pkg.sv
`default_nettype none

package tcic_pkg;

  // Result status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_NOT_IPV4  = 3'd2;
  localparam logic [2:0] STATUS_BAD_IHL   = 3'd3;
  localparam logic [2:0] STATUS_NOT_TCP   = 3'd4;
  localparam logic [2:0] STATUS_FRAGMENT  = 3'd5;
  localparam logic [2:0] STATUS_BAD_TOTAL = 3'd6;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd7;

  // Frame constants
  localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
  localparam logic [16:0] MIN_FRAME_LEN = 17'd40;
  localparam logic [6:0]  MIN_IHL_BYTES = 7'd20;
  localparam logic [6:0]  TCP_HDR_MIN   = 7'd20;
  localparam logic [6:0]  CSUM_FIELD    = 7'd16;
  localparam logic [7:0]  VERSION_MASK  = 8'hF0;
  localparam logic [7:0]  VERSION_IPV4  = 8'h40;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [15:0] FRAG_MASK     = 16'h3FFF;

  // Output packing in m_tdata
  localparam int STATUS_LSB = 0;
  localparam int CSUM_LSB   = 3;
  localparam int OFFSET_LSB = 19;

  // Captured state of one finished frame
  typedef struct packed {
    logic [16:0] len;
    logic [7:0]  vl;
    logic [7:0]  proto;
    logic [15:0] frag;
    logic [15:0] dlen;
    logic [15:0] sum;
  } tcic_frame_t;

  // Ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

### hdl/tcp_ipv4_tx_checksum_insert_top.sv
// TCP/IPv4 transmit checksum: feed one frame byte per request on the slave
// stream, starting at the first IPv4 header byte, with tlast on the final
// byte. Each frame yields exactly one result on the master stream, after
// its last byte passes the input, snapshot and result registers: the
// status (0 ok, 1 short, 2 not IPv4, 3 bad header length, 4 not TCP,
// 5 fragment, 6 bad total length, 7 too long), the checksum to insert and
// its byte offset, both zero unless the status is ok. Bytes are accepted at
// one per cycle unless a last byte finds the snapshot register full; the
// rate is set by the combinational end-around-carry accumulator in the
// byte stage. A pending result occupies only the output register and the
// snapshot register, so bytes flow on while it waits, up to a last byte.
`default_nettype none

module tcp_ipv4_tx_checksum_insert_top
  import tcic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [2:0] status, [18:3] checksum_value,
                                      // [25:19] checksum_offset, [31:26] zero
);

  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_last;
  logic        acc_ready;
  logic        snap_valid;
  logic        snap_ready;
  tcic_frame_t snap;

  assign s_tready = !a_valid || acc_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_byte <= s_tdata;
      a_last <= s_tlast;
    end
  end

  tcic_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (a_valid),
    .in_byte    (a_byte),
    .in_last    (a_last),
    .in_ready   (acc_ready),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  tcic_final u_final (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

### hdl/tcic_accum.sv
`default_nettype none

module tcic_accum
  import tcic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             in_ready,
  output logic             snap_valid,
  output tcic_frame_t      snap,
  input  wire logic        snap_ready
);

  logic [16:0] byte_count;
  logic [7:0]  vl;
  logic [7:0]  proto;
  logic [15:0] frag;
  logic [15:0] dlen;
  logic [15:0] sum;

  logic [7:0]  vl_next;
  logic [7:0]  proto_next;
  logic [15:0] frag_next;
  logic [15:0] dlen_next;
  logic [15:0] sum_next;
  logic [16:0] byte_count_next;
  logic [5:0]  ihl;
  logic        in_seg;
  logic        in_pseudo;
  logic [15:0] addend;
  logic        in_fire;

  // A last byte needs room in the snapshot register
  assign in_ready = !in_last || !snap_valid || snap_ready;
  assign in_fire  = in_valid && in_ready;

  // Capture header fields at their byte positions
  always_comb begin
    vl_next    = (byte_count == 17'd0) ? in_byte : vl;
    proto_next = (byte_count == 17'd9) ? in_byte : proto;
    frag_next  = frag;
    dlen_next  = dlen;
    if (byte_count == 17'd6) frag_next[15:8] = in_byte;
    if (byte_count == 17'd7) frag_next[7:0]  = in_byte;
    if (byte_count == 17'd2) dlen_next[15:8] = in_byte;
    if (byte_count == 17'd3) dlen_next[7:0]  = in_byte;
  end

  // Sum pseudo-header addresses and the segment bytes
  always_comb begin
    ihl       = {vl_next[3:0], 2'b00};
    in_seg    = (byte_count >= {11'd0, ihl}) && (byte_count < {1'b0, dlen_next});
    in_pseudo = (byte_count >= 17'd12) && (byte_count <= 17'd19);
    addend    = byte_count[0] ? {8'd0, in_byte} : {in_byte, 8'd0};
    sum_next  = (in_seg || in_pseudo) ? oc_add(sum, addend) : sum;
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 17'd1 : byte_count;
  end

  // Advance frame state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      vl         <= '0;
      proto      <= '0;
      frag       <= '0;
      dlen       <= '0;
      sum        <= '0;
    end else if (in_fire) begin
      if (in_last) begin
        byte_count <= '0;
        vl         <= '0;
        proto      <= '0;
        frag       <= '0;
        dlen       <= '0;
        sum        <= '0;
      end else begin
        byte_count <= byte_count_next;
        vl         <= vl_next;
        proto      <= proto_next;
        frag       <= frag_next;
        dlen       <= dlen_next;
        sum        <= sum_next;
      end
    end
  end

  // Hold the finished frame until the result stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_fire && in_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      snap.len   <= byte_count_next;
      snap.vl    <= vl_next;
      snap.proto <= proto_next;
      snap.frag  <= frag_next;
      snap.dlen  <= dlen_next;
      snap.sum   <= sum_next;
    end
  end

endmodule

`default_nettype wire

### hdl/tcic_final.sv
`default_nettype none

module tcic_final
  import tcic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        snap_valid,
  input  wire tcic_frame_t snap,
  output logic             snap_ready,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata
);

  logic [6:0]  ihl;
  logic [6:0]  ihl_min_total;
  logic [15:0] seg_len;
  logic [15:0] s1;
  logic [15:0] s2;
  logic [15:0] csum;
  logic [2:0]  status;
  logic [15:0] csum_out;
  logic [6:0]  off_out;

  assign snap_ready = !m_tvalid || m_tready;

  // Check the frame rules in order and finish the checksum
  always_comb begin
    ihl           = {1'b0, snap.vl[3:0], 2'b00};
    ihl_min_total = ihl + TCP_HDR_MIN;
    seg_len       = snap.dlen - {9'd0, ihl};
    s1            = oc_add(snap.sum, {8'd0, PROTO_TCP});
    s2            = oc_add(s1, seg_len);
    csum          = ~s2;
    csum_out      = '0;
    off_out       = '0;
    if (snap.len[16]) begin
      status = STATUS_TOO_LONG;
    end else if (snap.len < MIN_FRAME_LEN) begin
      status = STATUS_SHORT;
    end else if ((snap.vl & VERSION_MASK) != VERSION_IPV4) begin
      status = STATUS_NOT_IPV4;
    end else if (ihl < MIN_IHL_BYTES || {10'd0, ihl_min_total} > snap.len) begin
      status = STATUS_BAD_IHL;
    end else if (snap.proto != PROTO_TCP) begin
      status = STATUS_NOT_TCP;
    end else if ((snap.frag & FRAG_MASK) != 16'd0) begin
      status = STATUS_FRAGMENT;
    end else if ({1'b0, snap.dlen} > snap.len || snap.dlen < {9'd0, ihl_min_total}) begin
      status = STATUS_BAD_TOTAL;
    end else begin
      status   = STATUS_OK;
      csum_out = (csum == 16'd0) ? 16'hFFFF : csum;
      off_out  = ihl + CSUM_FIELD;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (snap_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      m_tdata <= {6'd0, off_out, csum_out, status};
    end
  end

endmodule

`default_nettype wire

### hdl/tcic_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tcic_checker
  import tcic_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // Hold a result that was not taken
  `ASSERT_CLKRST(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)
  // No result right after reset
  `ASSERT_CLK(a_reset_idle, clk, rst |=> !m_tvalid)
  // Failed frames carry no checksum and no offset
  `ASSERT_CLKRST(a_fail_zero, clk, rst, (m_tvalid && m_tdata[2:0] != STATUS_OK) |-> (m_tdata[25:3] == 23'd0))
  // Good frames carry a nonzero checksum at an offset inside a valid header
  `ASSERT_CLKRST(a_ok_fields, clk, rst, (m_tvalid && m_tdata[2:0] == STATUS_OK) |-> (m_tdata[18:3] != 16'd0 && m_tdata[25:19] >= 7'd36 && m_tdata[25:19] <= 7'd76))
  // Padding bits stay clear
  `ASSERT_CLKRST(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[31:26] == 6'd0))

endmodule

bind tcp_ipv4_tx_checksum_insert_top tcic_checker u_tcic_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
